// ===== sv/imm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package imm_pkg;

	localparam int MODE_W = 2;
	localparam int IDX_W = 3;
	localparam int DIM_W = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [MODE_W-1:0] MODE_LOAD_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOAD_SECOND = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MULTIPLY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_ROWS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_COLS = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic [DIM_W-1:0] first_rows;
		logic [DIM_W-1:0] first_cols;
		logic [DIM_W-1:0] second_rows;
		logic [DIM_W-1:0] second_cols;
	} dims_t;

	typedef struct packed {
		logic first;
		logic second;
	} wr_en_t;

	typedef struct packed {
		logic vld;
		logic first;
	} mac_ctl_t;

	typedef struct packed {
		logic             push;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             swapped;
		logic             error;
		logic             last;
	} out_push_t;

endpackage
`default_nettype wire

// ===== sv/imm_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
module imm_store #(
	parameter int DEPTH = 64,
	parameter int ADDR_W = 6,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  we,
	input  wire logic [ADDR_W-1:0]     waddr,
	input  wire logic [DATA_WIDTH-1:0] wdata,
	input  wire logic [ADDR_W-1:0]     raddr,
	output logic      [DATA_WIDTH-1:0] rdata_s1
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_s1 <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== sv/imm_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none
module imm_mac #(
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire imm_pkg::mac_ctl_t     ctl,
	input  wire logic [DATA_WIDTH-1:0] a_s1,
	input  wire logic [DATA_WIDTH-1:0] b_s1,
	output logic                       busy,
	output logic      [DATA_WIDTH-1:0] acc_q
);
	import imm_pkg::*;

	localparam int HW = (DATA_WIDTH + 1) / 2;
	localparam int LW = DATA_WIDTH - HW;

	logic                  vld_s1, first_s1;
	logic                  vld_s2, first_s2;
	logic [HW-1:0]         a_lo, b_lo;
	logic [LW-1:0]         a_hi, b_hi;
	logic [2*HW-1:0]       p_lo;
	logic [LW-1:0]         cross_a, cross_b;
	logic [DATA_WIDTH-1:0] p_lo_s2;
	logic [LW-1:0]         cross_s2;
	logic [DATA_WIDTH-1:0] prod;

	// low product bits only: signedness does not matter modulo 2^DATA_WIDTH
	assign a_lo = a_s1[HW-1:0];
	assign b_lo = b_s1[HW-1:0];
	assign a_hi = a_s1[DATA_WIDTH-1:HW];
	assign b_hi = b_s1[DATA_WIDTH-1:HW];
	assign p_lo = {{HW{1'b0}}, a_lo} * {{HW{1'b0}}, b_lo};
	assign cross_a = LW'(a_hi * b_lo);
	assign cross_b = LW'(a_lo * b_hi);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= ctl.vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= ctl.first;
		first_s2 <= first_s1;
		p_lo_s2 <= DATA_WIDTH'(p_lo);
		cross_s2 <= cross_a + cross_b;
	end

	assign prod = p_lo_s2 + {cross_s2, {HW{1'b0}}};

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			acc_q <= first_s2 ? prod : acc_q + prod;
		end
	end

	assign busy = vld_s1 | vld_s2;

endmodule
`default_nettype wire

// ===== sv/imm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module imm_ctrl #(
	parameter int MAX_DIM = 8,
	parameter int ADDR_W = 6
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [imm_pkg::MODE_W-1:0]   mode,
	input  wire logic [imm_pkg::IDX_W-1:0]    row,
	input  wire logic [imm_pkg::IDX_W-1:0]    col,
	input  wire imm_pkg::dims_t               dims,
	input  wire logic                         slot_free,
	input  wire logic                         mac_busy,
	output imm_pkg::wr_en_t                   wr_en,
	output logic      [ADDR_W-1:0]            wr_addr,
	output logic      [ADDR_W-1:0]            rd_addr_first,
	output logic      [ADDR_W-1:0]            rd_addr_second,
	output imm_pkg::mac_ctl_t                 mac_ctl,
	output imm_pkg::out_push_t                out_push
);
	import imm_pkg::*;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
		logic [DIM_W-1:0] res;
		res = d;
		if (d == '0) begin
			res = DIM_W'(1);
		end else if (d > DIM_W'(MAX_DIM)) begin
			res = DIM_W'(MAX_DIM);
		end
		return res;
	endfunction

	state_t           state_q, state_d;
	logic [IDX_W-1:0] i_q, i_d, j_q, j_d, r_q, r_d;
	logic [DIM_W-1:0] rows_q, rows_d, cols_q, cols_d, inner_q, inner_d;
	logic             swap_q, swap_d, err_q, err_d;
	logic [DIM_W-1:0] fr, fc, sr, sc;
	logic             accept, in_range, last_elem;
	logic [ADDR_W-1:0] left_addr, right_addr;

	assign fr = clamp_dim(dims.first_rows);
	assign fc = clamp_dim(dims.first_cols);
	assign sr = clamp_dim(dims.second_rows);
	assign sc = clamp_dim(dims.second_cols);

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid & s_tready;
	assign in_range = ({1'b0, row} < DIM_W'(MAX_DIM)) && ({1'b0, col} < DIM_W'(MAX_DIM));

	assign wr_addr = ADDR_W'(row * MAX_DIM + col);
	assign wr_en.first = accept && in_range && (mode == MODE_LOAD_FIRST);
	assign wr_en.second = accept && in_range && (mode == MODE_LOAD_SECOND);

	assign left_addr = ADDR_W'(i_q * MAX_DIM + r_q);
	assign right_addr = ADDR_W'(r_q * MAX_DIM + j_q);
	assign rd_addr_first = swap_q ? right_addr : left_addr;
	assign rd_addr_second = swap_q ? left_addr : right_addr;

	assign last_elem = err_q || (({1'b0, i_q} + DIM_W'(1) == rows_q) &&
		({1'b0, j_q} + DIM_W'(1) == cols_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q <= '0;
			j_q <= '0;
			r_q <= '0;
			rows_q <= DIM_W'(1);
			cols_q <= DIM_W'(1);
			inner_q <= DIM_W'(1);
			swap_q <= 1'b0;
			err_q <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q <= i_d;
			j_q <= j_d;
			r_q <= r_d;
			rows_q <= rows_d;
			cols_q <= cols_d;
			inner_q <= inner_d;
			swap_q <= swap_d;
			err_q <= err_d;
		end
	end

	always_comb begin
		state_d = state_q;
		i_d = i_q;
		j_d = j_q;
		r_d = r_q;
		rows_d = rows_q;
		cols_d = cols_q;
		inner_d = inner_q;
		swap_d = swap_q;
		err_d = err_q;
		mac_ctl = '0;
		out_push = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && mode == MODE_MULTIPLY) begin
					i_d = '0;
					j_d = '0;
					r_d = '0;
					err_d = 1'b0;
					state_d = ST_ISSUE;
					if (fc == sr) begin
						rows_d = fr;
						cols_d = sc;
						inner_d = fc;
						swap_d = 1'b0;
					end else if (fr == sc) begin
						rows_d = sr;
						cols_d = fc;
						inner_d = sc;
						swap_d = 1'b1;
					end else begin
						swap_d = 1'b0;
						err_d = 1'b1;
						state_d = ST_DRAIN;
					end
				end
			end
			ST_ISSUE: begin
				mac_ctl.vld = 1'b1;
				mac_ctl.first = (r_q == '0);
				if ({1'b0, r_q} + DIM_W'(1) == inner_q) begin
					r_d = '0;
					state_d = ST_DRAIN;
				end else begin
					r_d = r_q + IDX_W'(1);
				end
			end
			ST_DRAIN: begin
				if (!mac_busy && slot_free) begin
					out_push.push = 1'b1;
					out_push.row = err_q ? '0 : i_q;
					out_push.col = err_q ? '0 : j_q;
					out_push.swapped = swap_q & ~err_q;
					out_push.error = err_q;
					out_push.last = last_elem;
					if (last_elem) begin
						err_d = 1'b0;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_ISSUE;
						if ({1'b0, j_q} + DIM_W'(1) == cols_q) begin
							j_d = '0;
							i_d = i_q + IDX_W'(1);
						end else begin
							j_d = j_q + IDX_W'(1);
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_inner_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ISSUE |-> {1'b0, r_q} < inner_q)
		else $error("inner index past operand width");

	a_elem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && !err_q) |-> ({1'b0, i_q} < rows_q && {1'b0, j_q} < cols_q))
		else $error("result index outside product");

	a_err_no_issue: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |-> state_q != ST_ISSUE)
		else $error("dimension error run reads operands");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_push.push && out_push.last) |=> state_q == ST_IDLE)
		else $error("run continues after last result");

endmodule
`default_nettype wire

// ===== sv/integer_matrix_multiply.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | handshake          | payload
// s       | in  | s_tvalid/s_tready  | s_tdata {value, col, row}, s_tuser mode
// m       | out | m_tvalid/m_tready  | m_tdata {value_res, col_res, row_res},
//         |     |                    | m_tuser {error, swapped}, m_tlast last
// cfg     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// loads are taken back to back while no multiply runs
// a multiply runs each product element as one store read
// per inner term, then the two-stage multiply-accumulate drains
// a dimension error gives its single result through the drain state and the output register
// m_tready low holds the finished element; input is taken again once the run ends
// reset clears control and sets all dimensions to 1; store contents are undefined
module integer_matrix_multiply #(
	parameter int MAX_DIM = 8,
	parameter int DATA_WIDTH = 32,
	localparam int TDATA_W = ((2 * 3 + DATA_WIDTH + 7) / 8) * 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [TDATA_W-1:0]              s_tdata,   // row, col, value
	input  wire logic [imm_pkg::MODE_W-1:0]      s_tuser,   // mode
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic      [TDATA_W-1:0]              m_tdata,   // row_res, col_res, value_res
	output logic      [1:0]                      m_tuser,   // swapped, error
	output logic                                 m_tlast,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [imm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [imm_pkg::DIM_W-1:0]       cfg_data
);
	import imm_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	dims_t                 dims_q;
	wr_en_t                wr_en;
	mac_ctl_t              mac_ctl;
	out_push_t             out_push;
	logic [ADDR_W-1:0]     wr_addr, rd_addr_first, rd_addr_second;
	logic [DATA_WIDTH-1:0] first_s1, second_s1, acc;
	logic [DATA_WIDTH-1:0] in_value;
	logic [IDX_W-1:0]      in_row, in_col;
	logic                  mac_busy, slot_free;
	logic                  out_valid_q, out_swapped_q, out_error_q, out_last_q;
	logic [IDX_W-1:0]      out_row_q, out_col_q;
	logic [DATA_WIDTH-1:0] out_value_q;

	assign in_row = s_tdata[IDX_W-1:0];
	assign in_col = s_tdata[2*IDX_W-1:IDX_W];
	assign in_value = s_tdata[2*IDX_W+DATA_WIDTH-1:2*IDX_W];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q.first_rows <= DIM_W'(1);
			dims_q.first_cols <= DIM_W'(1);
			dims_q.second_rows <= DIM_W'(1);
			dims_q.second_cols <= DIM_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FIRST_ROWS: dims_q.first_rows <= cfg_data;
				CFG_FIRST_COLS: dims_q.first_cols <= cfg_data;
				CFG_SECOND_ROWS: dims_q.second_rows <= cfg_data;
				CFG_SECOND_COLS: dims_q.second_cols <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	imm_ctrl #(
		.MAX_DIM(MAX_DIM),
		.ADDR_W(ADDR_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.mode(s_tuser),
		.row(in_row),
		.col(in_col),
		.dims(dims_q),
		.slot_free(slot_free),
		.mac_busy(mac_busy),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.rd_addr_first(rd_addr_first),
		.rd_addr_second(rd_addr_second),
		.mac_ctl(mac_ctl),
		.out_push(out_push)
	);

	imm_store #(
		.DEPTH(DEPTH),
		.ADDR_W(ADDR_W),
		.DATA_WIDTH(DATA_WIDTH)
	) u_first_store (
		.clk(clk),
		.we(wr_en.first),
		.waddr(wr_addr),
		.wdata(in_value),
		.raddr(rd_addr_first),
		.rdata_s1(first_s1)
	);

	imm_store #(
		.DEPTH(DEPTH),
		.ADDR_W(ADDR_W),
		.DATA_WIDTH(DATA_WIDTH)
	) u_second_store (
		.clk(clk),
		.we(wr_en.second),
		.waddr(wr_addr),
		.wdata(in_value),
		.raddr(rd_addr_second),
		.rdata_s1(second_s1)
	);

	imm_mac #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(mac_ctl),
		.a_s1(first_s1),
		.b_s1(second_s1),
		.busy(mac_busy),
		.acc_q(acc)
	);

	assign slot_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_push.push) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_push.push) begin
			out_row_q <= out_push.row;
			out_col_q <= out_push.col;
			out_value_q <= out_push.error ? '0 : acc;
			out_swapped_q <= out_push.swapped;
			out_error_q <= out_push.error;
			out_last_q <= out_push.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = TDATA_W'({out_value_q, out_col_q, out_row_q});
	assign m_tuser = {out_error_q, out_swapped_q};
	assign m_tlast = out_last_q;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import imm_pkg::*;

	localparam int DIM = 8;
	localparam int TDATA_W = 40;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 110;

	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [31:0]      value;
		logic             swapped;
		logic             error;
		logic             last;
	} product_t;

	typedef struct packed {
		logic              is_cfg;
		logic [MODE_W-1:0] mode;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [31:0]       value;
		logic [15:0]       dims;     // first_rows, first_cols, second_rows, second_cols
		logic              typed;
		product_t          want;
	} plan_t;

	localparam product_t NO_PRODUCT = '0;
	localparam product_t EXTREME_PRODUCT = '{3'd0, 3'd0, 32'h8000_0000, 1'b0, 1'b0, 1'b1};
	localparam product_t ERROR_PRODUCT = '{3'd0, 3'd0, 32'd0, 1'b0, 1'b1, 1'b1};

	localparam plan_t PLAN [14] = '{
		'{1'b0, MODE_LOAD_FIRST, 3'd0, 3'd0, 32'h7fff_ffff, 16'h0, 1'b0, NO_PRODUCT},
		'{1'b0, MODE_LOAD_SECOND, 3'd0, 3'd0, 32'h8000_0000, 16'h0, 1'b0, NO_PRODUCT},
		'{1'b0, MODE_MULTIPLY, 3'd0, 3'd0, 32'h0, 16'h0, 1'b1, EXTREME_PRODUCT},
		'{1'b0, MODE_UNUSED, 3'd7, 3'd7, 32'hffff_ffff, 16'h0, 1'b0, NO_PRODUCT},
		'{1'b0, MODE_MULTIPLY, 3'd7, 3'd7, 32'hffff_ffff, 16'h0, 1'b1, EXTREME_PRODUCT},
		'{1'b0, MODE_LOAD_FIRST, 3'd0, 3'd1, 32'hffff_ffff, 16'h0, 1'b0, NO_PRODUCT},
		'{1'b0, MODE_LOAD_FIRST, 3'd7, 3'd7, 32'h5555_5555, 16'h0, 1'b0, NO_PRODUCT},
		'{1'b0, MODE_LOAD_SECOND, 3'd7, 3'd7, 32'haaaa_aaaa, 16'h0, 1'b0, NO_PRODUCT},
		'{1'b1, MODE_LOAD_FIRST, 3'd0, 3'd0, 32'h0, 16'h1211, 1'b0, NO_PRODUCT},
		'{1'b0, MODE_MULTIPLY, 3'd0, 3'd0, 32'h0, 16'h0, 1'b0, NO_PRODUCT},
		'{1'b1, MODE_LOAD_FIRST, 3'd0, 3'd0, 32'h0, 16'h02f8, 1'b0, NO_PRODUCT},
		'{1'b0, MODE_MULTIPLY, 3'd5, 3'd2, 32'h1234_5678, 16'h0, 1'b1, ERROR_PRODUCT},
		'{1'b1, MODE_LOAD_FIRST, 3'd0, 3'd0, 32'h0, 16'h1111, 1'b0, NO_PRODUCT},
		'{1'b0, MODE_MULTIPLY, 3'd0, 3'd0, 32'h0, 16'h0, 1'b0, NO_PRODUCT}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [TDATA_W-1:0]   s_tdata = '0;
	logic [MODE_W-1:0]    s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [TDATA_W-1:0]   m_tdata;
	logic [1:0]           m_tuser;
	logic                 m_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0]     cfg_data = '0;

	logic [31:0]      first_mem [DIM*DIM];
	logic [31:0]      second_mem [DIM*DIM];
	bit               first_set [DIM*DIM];
	bit               second_set [DIM*DIM];
	logic [DIM_W-1:0] dim_fr = 4'd1;
	logic [DIM_W-1:0] dim_fc = 4'd1;
	logic [DIM_W-1:0] dim_sr = 4'd1;
	logic [DIM_W-1:0] dim_sc = 4'd1;

	product_t product_q [$];
	product_t got;
	product_t want;
	int       fail_cnt = 0;
	int       sent_cnt = 0;
	int       send_idle = 14;
	int       recv_idle = 68;
	bit       hold_req = 1'b0;
	bit       hold_done = 1'b0;
	int       hold_left = 0;

	integer_matrix_multiply u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int eff_dim(input logic [DIM_W-1:0] d);
		if (d == 0) return 1;
		if (d > DIM) return DIM;
		return int'(d);
	endfunction

	function automatic logic [31:0] rand_value();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3, 4: return 32'($signed($urandom_range(20)) - 10);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		case ($urandom_range(11))
			0: return 4'd0;
			1: return 4'd15;
			2: return 4'd8;
			3: return 4'($urandom_range(7, 4));
			default: return 4'($urandom_range(3, 1));
		endcase
	endfunction

	function automatic void predict_product();
		int          fr, fc, sr, sc, out_r, out_c, inner;
		bit          swp;
		logic [31:0] acc, a, b;
		product_t    p;
		fr = eff_dim(dim_fr);
		fc = eff_dim(dim_fc);
		sr = eff_dim(dim_sr);
		sc = eff_dim(dim_sc);
		if (fc == sr) begin
			swp = 1'b0; out_r = fr; out_c = sc; inner = fc;
		end else if (fr == sc) begin
			swp = 1'b1; out_r = sr; out_c = fc; inner = sc;
		end else begin
			product_q.push_back(ERROR_PRODUCT);
			return;
		end
		for (int i = 0; i < out_r; i++) begin
			for (int j = 0; j < out_c; j++) begin
				acc = '0;
				for (int r = 0; r < inner; r++) begin
					a = swp ? second_mem[i*DIM+r] : first_mem[i*DIM+r];
					b = swp ? first_mem[r*DIM+j] : second_mem[r*DIM+j];
					acc = acc + a * b;
				end
				p.row = 3'(i);
				p.col = 3'(j);
				p.value = acc;
				p.swapped = swp;
				p.error = 1'b0;
				p.last = (i == out_r - 1) && (j == out_c - 1);
				product_q.push_back(p);
			end
		end
	endfunction

	task automatic send_item(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col, input logic [31:0] value, input bit predict);
		if ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, value, col, row};
		s_tuser <= mode;
		do @(posedge clk); while (!s_tready);
		if (mode == MODE_LOAD_FIRST) begin
			first_mem[{row, col}] = value;
			first_set[{row, col}] = 1'b1;
		end else if (mode == MODE_LOAD_SECOND) begin
			second_mem[{row, col}] = value;
			second_set[{row, col}] = 1'b1;
		end else if (mode == MODE_MULTIPLY && predict) begin
			predict_product();
		end
		if (mode != MODE_UNUSED)
			sent_cnt++;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (product_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_FIRST_ROWS: dim_fr = data;
			CFG_FIRST_COLS: dim_fc = data;
			CFG_SECOND_ROWS: dim_sr = data;
			CFG_SECOND_COLS: dim_sc = data;
			default: ;
		endcase
	endtask

	task automatic write_dims(input logic [DIM_W-1:0] fr, input logic [DIM_W-1:0] fc,
			input logic [DIM_W-1:0] sr, input logic [DIM_W-1:0] sc);
		settle();
		cfg_write(CFG_FIRST_ROWS, fr);
		cfg_write(CFG_FIRST_COLS, fc);
		cfg_write(CFG_SECOND_ROWS, sr);
		cfg_write(CFG_SECOND_COLS, sc);
		cfg_valid <= 1'b0;
	endtask

	// mostly inside the configured shape so products see fresh data
	task automatic random_load();
		logic [MODE_W-1:0] tgt;
		int                r, c;
		tgt = $urandom_range(1) ? MODE_LOAD_FIRST : MODE_LOAD_SECOND;
		if ($urandom_range(3) == 0) begin
			r = $urandom_range(DIM - 1);
			c = $urandom_range(DIM - 1);
		end else if (tgt == MODE_LOAD_FIRST) begin
			r = $urandom_range(eff_dim(dim_fr) - 1);
			c = $urandom_range(eff_dim(dim_fc) - 1);
		end else begin
			r = $urandom_range(eff_dim(dim_sr) - 1);
			c = $urandom_range(eff_dim(dim_sc) - 1);
		end
		send_item(tgt, 3'(r), 3'(c), rand_value(), 1'b1);
	endtask

	task automatic random_round();
		logic [DIM_W-1:0] d [4];
		int               segs;
		bit               hold_now;
		for (int k = 0; k < 4; k++)
			d[k] = pick_dim();
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: d[2] = d[1];
			6, 7: d[3] = d[0];
			default: ;
		endcase
		write_dims(d[0], d[1], d[2], d[3]);
		segs = $urandom_range(2, 1);
		repeat (segs) begin
			repeat ($urandom_range(6)) begin
				if ($urandom_range(9) == 0)
					send_item(MODE_UNUSED, 3'($urandom), 3'($urandom), $urandom, 1'b1);
				else
					random_load();
			end
			// every operand entry the product reads must hold data
			if (eff_dim(d[1]) == eff_dim(d[2]) || eff_dim(d[0]) == eff_dim(d[3])) begin
				for (int r = 0; r < eff_dim(d[0]); r++)
					for (int c = 0; c < eff_dim(d[1]); c++)
						if (!first_set[r*DIM+c])
							send_item(MODE_LOAD_FIRST, 3'(r), 3'(c), rand_value(), 1'b1);
				for (int r = 0; r < eff_dim(d[2]); r++)
					for (int c = 0; c < eff_dim(d[3]); c++)
						if (!second_set[r*DIM+c])
							send_item(MODE_LOAD_SECOND, 3'(r), 3'(c), rand_value(), 1'b1);
			end
			hold_now = !hold_done && eff_dim(d[1]) == eff_dim(d[2])
				&& eff_dim(d[0]) * eff_dim(d[3]) >= 4;
			if (hold_now) begin
				hold_done = 1'b1;
				hold_req = 1'b1;
			end
			send_item(MODE_MULTIPLY, 3'($urandom), 3'($urandom), $urandom, 1'b1);
			// keep requests queued behind the stalled run
			if (hold_now)
				repeat (6) random_load();
		end
	endtask

	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[2:0], m_tdata[5:3], m_tdata[37:6], m_tuser[0], m_tuser[1], m_tlast};
			if (product_q.size() == 0) begin
				if (fail_cnt < 10)
					$display("unexpected product: row %0d col %0d value %h swp %b err %b last %b",
						got.row, got.col, got.value, got.swapped, got.error, got.last);
				fail_cnt++;
			end else begin
				want = product_q.pop_front();
				if (got !== want) begin
					if (fail_cnt < 10) begin
						$display("mismatch exp: row %0d col %0d value %h swp %b err %b last %b",
							want.row, want.col, want.value, want.swapped, want.error, want.last);
						$display("         got: row %0d col %0d value %h swp %b err %b last %b",
							got.row, got.col, got.value, got.swapped, got.error, got.last);
					end
					fail_cnt++;
				end
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int n = 0; n < $size(PLAN); n++) begin
			if (PLAN[n].is_cfg) begin
				write_dims(PLAN[n].dims[15:12], PLAN[n].dims[11:8], PLAN[n].dims[7:4],
					PLAN[n].dims[3:0]);
			end else begin
				send_item(PLAN[n].mode, PLAN[n].row, PLAN[n].col, PLAN[n].value, !PLAN[n].typed);
				if (PLAN[n].typed)
					product_q.push_back(PLAN[n].want);
			end
		end
		sent_cnt = 0;
		while (sent_cnt < RANDOM_ITEMS) begin
			if (sent_cnt < RANDOM_ITEMS / 3) begin
				send_idle = 14;
				recv_idle = 68;
			end else if (sent_cnt < 2 * RANDOM_ITEMS / 3) begin
				send_idle = 68;
				recv_idle = 14;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			random_round();
		end
		settle();
		if (fail_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
